### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clk_i edge, held off while rst_ni is low.
`define ITR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clk_i edge, also during reset.
`define ITR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/itr_pkg.sv
// Package for the integer to Roman numeral converter: widths, token table, control types.
package itr_pkg;

  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned NUM_TOK  = 13;
  localparam int unsigned TOK_W    = $clog2(NUM_TOK);

  localparam logic [VALUE_W-1:0] MAX_VALID = VALUE_W'(3999);
  localparam logic [TOK_W-1:0]   TOK_ONE   = TOK_W'(NUM_TOK - 1);
  localparam logic [SYMBOL_W-1:0] NO_SYM   = 8'h00;

  // Greedy tokens, largest first: M CM D CD C XC L XL X IX V IV I.
  localparam logic [VALUE_W-1:0] TOK_VAL [NUM_TOK] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };
  localparam logic [SYMBOL_W-1:0] TOK_FIRST [NUM_TOK] = '{
    "M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
  };
  // Second letter of a subtractive pair, NO_SYM for single letters.
  localparam logic [SYMBOL_W-1:0] TOK_SECOND [NUM_TOK] = '{
    8'h00, "M", 8'h00, "D", 8'h00, "C", 8'h00, "L", 8'h00, "X", 8'h00, "V", 8'h00
  };

  typedef struct packed {
    logic load;
    logic step;
  } itr_cmd_t;

  typedef struct packed {
    logic last;
  } itr_sts_t;

endpackage

### rtl/itr_intf.sv
// Valid/ready channel interfaces for the input values and the output characters.
interface itr_in_if;
  import itr_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itr_out_if;
  import itr_pkg::*;

  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;
  logic                range_error;

  modport source (output valid, output symbol, output last, output range_error, input ready);
  modport sink (input valid, input symbol, input last, input range_error, output ready);
endinterface

### rtl/itr_ctrl.sv
// Controller: accepts a value, then steps the datapath once per character.
`include "assert_macros.svh"

module itr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_ready_i,
  input  itr_pkg::itr_sts_t sts_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output itr_pkg::itr_cmd_t cmd_o
);
  import itr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic can_step;

  assign can_step   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        if (can_step) begin
          cmd_o.step  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ITR_ASSERT_ALWAYS(a_load_step_excl, !(cmd_o.load && cmd_o.step), "load and step together")
  `ITR_ASSERT(a_step_fills_out, cmd_o.step |=> out_valid_q, "step did not fill output")
  `ITR_ASSERT(a_stall_holds, out_valid_q && !out_ready_i |=> out_valid_q, "stalled char dropped")
  `ITR_ASSERT(a_load_runs, cmd_o.load |=> (state_q == S_RUN), "load did not start run")

endmodule

### rtl/itr_dp.sv
// Datapath: remainder register, greedy token select and output character register.
`include "assert_macros.svh"

module itr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itr_pkg::itr_cmd_t             cmd_i,
  input  logic [itr_pkg::VALUE_W-1:0]   value_i,
  output itr_pkg::itr_sts_t             sts_o,
  output logic [itr_pkg::SYMBOL_W-1:0]  symbol_o,
  output logic                          last_o,
  output logic                          range_error_o
);
  import itr_pkg::*;

  logic [VALUE_W-1:0]  rem_q, rem_d;
  logic                err_q;
  logic                pend_q;
  logic [SYMBOL_W-1:0] pend_sym_q;
  logic [SYMBOL_W-1:0] sym_q;
  logic                last_q;
  logic                rerr_q;

  logic [TOK_W-1:0]    idx;
  logic                two;
  logic [SYMBOL_W-1:0] sym_d;
  logic                last_d;

  // Largest token not above the remainder.
  always_comb begin
    idx = TOK_ONE;
    for (int i = NUM_TOK - 1; i >= 0; i--) begin
      if (rem_q >= TOK_VAL[i]) begin
        idx = TOK_W'(i);
      end
    end
  end

  assign two = (TOK_SECOND[idx] != NO_SYM);

  always_comb begin
    if (err_q) begin
      sym_d  = NO_SYM;
      rem_d  = rem_q;
      last_d = 1'b1;
    end else if (pend_q) begin
      sym_d  = pend_sym_q;
      rem_d  = rem_q;
      last_d = (rem_q == '0);
    end else begin
      sym_d  = TOK_FIRST[idx];
      rem_d  = rem_q - TOK_VAL[idx];
      last_d = !two && (rem_d == '0);
    end
  end

  assign sts_o.last = last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (cmd_i.load) begin
      pend_q <= 1'b0;
    end else if (cmd_i.step) begin
      pend_q <= !pend_q && !err_q && two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= value_i;
      err_q <= (value_i == '0) || (value_i > MAX_VALID);
    end else if (cmd_i.step) begin
      rem_q      <= rem_d;
      pend_sym_q <= TOK_SECOND[idx];
      sym_q      <= sym_d;
      last_q     <= last_d;
      rerr_q     <= err_q;
    end
  end

  assign symbol_o      = sym_q;
  assign last_o        = last_q;
  assign range_error_o = rerr_q;

  `ITR_ASSERT(a_err_single, err_q && cmd_i.step |-> sts_o.last, "error gave more than one char")
  `ITR_ASSERT(a_pair_done, pend_q && cmd_i.step |=> !pend_q, "second letter pending twice")

endmodule

### rtl/integer_to_roman_numeral.sv
// Top level of the integer to Roman numeral converter.
// Takes a 12-bit unsigned value and sends its Roman numeral (subtractive form) as one
// ASCII capital letter per output transaction, most significant first, with last set
// on the final letter. Values 0 and 4000 to 4095 give one transaction with symbol 0,
// last 1 and range_error 1. A loaded value gives 1 to 15 letters, one per cycle while
// the output is not stalled, made by greedy subtraction on a remainder register (the second
// letter of a subtractive pair takes a step of its own). The next value is accepted as soon
// as the last letter has moved into the output register, while that letter still waits.
module integer_to_roman_numeral (
  input  logic       clk_i,
  input  logic       rst_ni,
  itr_in_if.sink     in_i,
  itr_out_if.source  out_o
);
  import itr_pkg::*;

  itr_cmd_t cmd;
  itr_sts_t sts;

  itr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  itr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .value_i       (in_i.value),
    .sts_o         (sts),
    .symbol_o      (out_o.symbol),
    .last_o        (out_o.last),
    .range_error_o (out_o.range_error)
  );

endmodule

### verif/itr_checker.sv
// Checker for the Roman numeral converter: predicts the letters and compares them.
`timescale 1ns / 1ps

module itr_checker (
  input  logic clk_i,
  input  logic rst_ni,
  itr_in_if    in_i,
  itr_out_if   out_i,
  output int   errors_o,
  output int   pending_o
);
  import itr_pkg::*;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                range_error;
  } letter_t;

  letter_t letter_q[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors_o++;
  endtask

  function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
    int unsigned         scale [3] = '{100, 10, 1};
    int unsigned         place;
    int unsigned         d;
    int unsigned         k;
    logic [SYMBOL_W-1:0] one_l, five_l, ten_l;
    logic [SYMBOL_W-1:0] letters[$];
    letter_t             e;
    if (v == '0 || v > MAX_VALID) begin
      e.symbol      = NO_SYM;
      e.last        = 1'b1;
      e.range_error = 1'b1;
      letter_q.push_back(e);
      return;
    end
    repeat (v / 1000) letters.push_back("M");
    for (place = 0; place < 3; place++) begin
      case (place)
        0: begin
          one_l = "C"; five_l = "D"; ten_l = "M";
        end
        1: begin
          one_l = "X"; five_l = "L"; ten_l = "C";
        end
        default: begin
          one_l = "I"; five_l = "V"; ten_l = "X";
        end
      endcase
      d = (v / scale[place]) % 10;
      if (d == 9) begin
        letters.push_back(one_l);
        letters.push_back(ten_l);
      end else if (d == 4) begin
        letters.push_back(one_l);
        letters.push_back(five_l);
      end else begin
        if (d >= 5) letters.push_back(five_l);
        repeat (d % 5) letters.push_back(one_l);
      end
    end
    for (k = 0; k < letters.size(); k++) begin
      e.symbol      = letters[k];
      e.last        = (k + 1 == letters.size());
      e.range_error = 1'b0;
      letter_q.push_back(e);
    end
  endfunction

  always @(posedge clk_i) begin
    letter_t e;
    if (rst_ni) begin
      if (out_i.valid && out_i.ready) begin
        if (letter_q.size() == 0) begin
          report_mismatch($sformatf("unexpected letter 0x%02h last %0b err %0b",
                                    out_i.symbol, out_i.last, out_i.range_error));
        end else begin
          e = letter_q.pop_front();
          if (out_i.symbol !== e.symbol)
            report_mismatch($sformatf("symbol 0x%02h, expected 0x%02h",
                                      out_i.symbol, e.symbol));
          if (out_i.last !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b (symbol 0x%02h)",
                                      out_i.last, e.last, e.symbol));
          if (out_i.range_error !== e.range_error)
            report_mismatch($sformatf("range_error %0b, expected %0b",
                                      out_i.range_error, e.range_error));
        end
      end
      if (in_i.valid && in_i.ready) predict_numeral(in_i.value);
      pending_o = letter_q.size();
    end
  end

endmodule

### verif/tb_integer_to_roman_numeral.sv
// Testbench top for the Roman numeral converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_integer_to_roman_numeral;
  import itr_pkg::*;

  localparam int unsigned RAND_PER_PHASE = 145;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned STALL_LIMIT    = 2000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int          errors;
  int          pending;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned stall_cycles;

  itr_in_if  in_ch ();
  itr_out_if out_ch ();

  integer_to_roman_numeral DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  itr_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    src_idle_pct = 11;
    snk_idle_pct = 55;
    stall_cycles = 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 12) return VALUE_W'($urandom_range(4095, 4000));
    if (r < 22) return VALUE_W'($urandom_range(3999, 3000));
    return VALUE_W'($urandom_range(3999, 1));
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_value(random_value());
  endtask

  initial begin
    logic [VALUE_W-1:0] directed [] = '{
      12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd5,
      12'd9, 12'd40, 12'd49, 12'd90, 12'd400, 12'd499, 12'd900, 12'd1994,
      12'd2444, 12'd3000, 12'd1000, 12'd2048, 12'd8, 12'd1666, 12'd4094,
      12'd2730, 12'd1365
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_value(directed[i]);
    send_random(RAND_PER_PHASE);

    src_idle_pct = 55;
    snk_idle_pct = 11;
    send_random(RAND_PER_PHASE);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(RAND_PER_PHASE);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
